// ===== rtl/pwf_pkg.sv =====
// Package with the constants, codes and arithmetic helpers of the PID core.
`timescale 1ns / 1ps

package pwf_pkg;

   localparam int unsigned LIM_W = 31;

   localparam int unsigned PI_VAL = 205887;
   localparam int unsigned TWO_PI_VAL = 2 * PI_VAL;

   // Width of the wrap remainder, which stays below twice the period.
   localparam int unsigned REM_W = 20;
   localparam int unsigned QUOT_W = 15;
   localparam int unsigned MAG_W = 33;
   localparam int unsigned RECIP_SHIFT = 34;
   localparam int unsigned RECIP_W = 16;
   localparam int unsigned PROD_W = MAG_W + RECIP_W;

   localparam logic [REM_W-1:0] TWO_PI_Q16 = REM_W'(TWO_PI_VAL);
   localparam logic [REM_W-1:0] PI_M1_Q16 = REM_W'(PI_VAL - 1);
   localparam logic [RECIP_W-1:0] RECIP_Q =
      RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(TWO_PI_VAL));

   localparam logic [1:0] FUNC_CALC = 2'd0;
   localparam logic [1:0] FUNC_ALIGN = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;
   localparam logic [1:0] FUNC_ZERO = 2'd3;

   localparam logic [2:0] CSR_KP = 3'd0;
   localparam logic [2:0] CSR_KI = 3'd1;
   localparam logic [2:0] CSR_KD = 3'd2;
   localparam logic [2:0] CSR_KF = 3'd3;
   localparam logic [2:0] CSR_INTEG_LIM = 3'd4;
   localparam logic [2:0] CSR_MAX_OUT = 3'd5;
   localparam logic [2:0] CSR_ANGLE_MODE = 3'd6;

   function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v[32] != v[31]) begin
         r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Q16.16 product, rounded half up, saturated to 32 bits.
   function automatic logic signed [31:0] mul_q16(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [63:0] prod;
      logic signed [63:0] shifted;
      logic signed [31:0] r;
      prod = a * b;
      shifted = (prod + 64'sd32768) >>> 16;
      if ((shifted[63:31] == '0) || (shifted[63:31] == '1)) begin
         r = shifted[31:0];
      end else begin
         r = shifted[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end
      return r;
   endfunction

   function automatic logic signed [31:0] clamp_sym(input logic signed [33:0] v,
                                                    input logic [30:0] lim);
      logic signed [33:0] hi;
      logic signed [33:0] lo;
      logic signed [31:0] r;
      hi = signed'({3'b000, lim});
      lo = -hi;
      priority if (v > hi) begin
         r = hi[31:0];
      end else if (v < lo) begin
         r = lo[31:0];
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/pid_with_feedforward_core.sv =====
// Top level of the positional PID controller with setpoint feedforward.
`timescale 1ns / 1ps

// Positional PID controller with setpoint feedforward in signed Q16.16. The core
// takes one item per clock cycle when the result side does not stall, and
// returns one drive item for each. A six-stage pipeline does the work: error
// forming with the angle wrap done as a reciprocal multiply and a constant
// multiply, the change terms, the four gain multipliers, the integral update and
// the final sum and clamp, followed by the result register. The error history
// and the integral are kept in the stage that uses them, so consecutive items
// see each other's updates with no gap. A stall on the result side while a
// result waits holds the whole pipeline and raises req_stall.
// The user must write gains, limits and angle mode through the csr port only
// while the core holds no item; the core itself does not enforce this.
module pid_with_feedforward_core
   import pwf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic signed [31:0] req_setpoint,
   input  logic signed [31:0] req_feedback,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_drive,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic signed [31:0] kp_ff, ki_ff, kd_ff, kf_ff;
   logic [LIM_W-1:0] integ_lim_ff, max_out_ff;
   logic angle_mode_ff;

   logic adv;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, s6_valid_ff;
   logic rsp_valid_ff;

   logic [1:0] s1_func_ff, s2_func_ff, s3_func_ff, s4_func_ff, s5_func_ff, s6_func_ff;
   logic signed [31:0] s1_setpoint_ff, s1_feedback_ff;
   logic signed [31:0] s2_setpoint_ff, s3_setpoint_ff;

   logic signed [32:0] s1_diff;
   logic s1_neg;
   logic [MAG_W-1:0] s1_mag;
   logic [MAG_W-1:0] s1_wrap_in;
   logic [PROD_W-1:0] s1_prod;
   logic [QUOT_W-1:0] s1_quot_in;

   logic signed [32:0] s2_diff_ff;
   logic s2_neg_ff;
   logic [MAG_W-1:0] s2_wrap_ff;
   logic [QUOT_W-1:0] s2_quot_ff;
   logic [33:0] s2_nt;
   logic [REM_W-1:0] s2_rem_raw;
   logic [REM_W-1:0] s2_rem;
   logic signed [REM_W-1:0] s2_mod;
   logic signed [REM_W-1:0] s2_wrapped;
   logic signed [31:0] s2_error_in;

   logic signed [31:0] s3_error_ff;
   logic signed [31:0] prev_error_ff, prev_setpoint_ff;
   logic signed [31:0] prev_error_in, prev_setpoint_in;
   logic signed [31:0] s3_derr_in, s3_dset_in;

   logic signed [31:0] s4_error_ff, s4_derr_ff, s4_dset_ff;
   logic signed [31:0] s4_p_in, s4_ie_in, s4_d_in, s4_f_in;

   logic signed [31:0] s5_p_ff, s5_ie_ff, s5_d_ff, s5_f_ff;
   logic signed [31:0] integral_ff;
   logic signed [31:0] integral_in;
   logic signed [31:0] s5_integ_sat;

   logic signed [31:0] s6_p_ff, s6_i_ff, s6_d_ff, s6_f_ff;
   logic signed [33:0] s6_sum;
   logic signed [31:0] drive_in;
   logic signed [31:0] rsp_drive_ff;

   assign adv = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff <= '0;
         ki_ff <= '0;
         kd_ff <= '0;
         kf_ff <= '0;
         integ_lim_ff <= '0;
         max_out_ff <= '0;
         angle_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_KP: kp_ff <= signed'(csr_wdata);
            CSR_KI: ki_ff <= signed'(csr_wdata);
            CSR_KD: kd_ff <= signed'(csr_wdata);
            CSR_KF: kf_ff <= signed'(csr_wdata);
            CSR_INTEG_LIM: integ_lim_ff <= csr_wdata[LIM_W-1:0];
            CSR_MAX_OUT: max_out_ff <= csr_wdata[LIM_W-1:0];
            CSR_ANGLE_MODE: angle_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Stage one: raw difference and the quotient estimate for the angle wrap.
   always_comb begin
      s1_diff = {s1_setpoint_ff[31], s1_setpoint_ff} - {s1_feedback_ff[31], s1_feedback_ff};
      s1_neg = s1_diff[32];
      s1_mag = s1_neg ? MAG_W'(-s1_diff) : MAG_W'(s1_diff);
      s1_wrap_in = s1_mag + MAG_W'(PI_M1_Q16);
      s1_prod = PROD_W'(s1_wrap_in) * PROD_W'(RECIP_Q);
      s1_quot_in = s1_prod[PROD_W-1 -: QUOT_W];
   end

   // Stage two: exact remainder with one correction step, then the signed error.
   always_comb begin
      s2_nt = 34'(s2_quot_ff) * 34'(TWO_PI_Q16);
      s2_rem_raw = REM_W'(34'(s2_wrap_ff) - s2_nt);
      s2_rem = (s2_rem_raw >= TWO_PI_Q16) ? s2_rem_raw - TWO_PI_Q16 : s2_rem_raw;
      s2_mod = signed'(s2_rem) - signed'(PI_M1_Q16);
      s2_wrapped = s2_neg_ff ? -s2_mod : s2_mod;
      s2_error_in = angle_mode_ff ? 32'(s2_wrapped) : sat33(s2_diff_ff);
   end

   // Stage three: error and setpoint history, and the change terms.
   always_comb begin
      s3_derr_in = sat33({s3_error_ff[31], s3_error_ff} - {prev_error_ff[31], prev_error_ff});
      s3_dset_in = sat33({s3_setpoint_ff[31], s3_setpoint_ff}
                         - {prev_setpoint_ff[31], prev_setpoint_ff});
      unique case (s3_func_ff)
         FUNC_CALC, FUNC_ALIGN: begin
            prev_error_in = s3_error_ff;
            prev_setpoint_in = s3_setpoint_ff;
         end
         FUNC_CLEAR: begin
            prev_error_in = prev_error_ff;
            prev_setpoint_in = s3_setpoint_ff;
         end
         default: begin
            prev_error_in = '0;
            prev_setpoint_in = '0;
         end
      endcase
   end

   // Stage four: the gain products.
   always_comb begin
      s4_p_in = mul_q16(kp_ff, s4_error_ff);
      s4_ie_in = mul_q16(ki_ff, s4_error_ff);
      s4_d_in = mul_q16(kd_ff, s4_derr_ff);
      s4_f_in = mul_q16(kf_ff, s4_dset_ff);
   end

   // Stage five: integral accumulation with saturation and clamp, or clear for the other functions.
   always_comb begin
      s5_integ_sat = sat33({integral_ff[31], integral_ff} + {s5_ie_ff[31], s5_ie_ff});
      if (s5_func_ff == FUNC_CALC) begin
         integral_in = clamp_sym({{2{s5_integ_sat[31]}}, s5_integ_sat}, integ_lim_ff);
      end else begin
         integral_in = '0;
      end
   end

   // Stage six: total drive and output clamp, or zero drive for the other functions.
   always_comb begin
      s6_sum = 34'(s6_p_ff) + 34'(s6_i_ff) + 34'(s6_d_ff) + 34'(s6_f_ff);
      if (s6_func_ff == FUNC_CALC) begin
         drive_in = clamp_sym(s6_sum, max_out_ff);
      end else begin
         drive_in = '0;
      end
   end

   // Control state, valid bits and controller state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prev_error_ff <= '0;
         prev_setpoint_ff <= '0;
         integral_ff <= '0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
         rsp_valid_ff <= s6_valid_ff;
         if (s3_valid_ff) begin
            prev_error_ff <= prev_error_in;
            prev_setpoint_ff <= prev_setpoint_in;
         end
         if (s5_valid_ff) begin
            integral_ff <= integral_in;
         end
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_func_ff <= req_func;
         s1_setpoint_ff <= req_setpoint;
         s1_feedback_ff <= req_feedback;

         s2_func_ff <= s1_func_ff;
         s2_setpoint_ff <= s1_setpoint_ff;
         s2_diff_ff <= s1_diff;
         s2_neg_ff <= s1_neg;
         s2_wrap_ff <= s1_wrap_in;
         s2_quot_ff <= s1_quot_in;

         s3_func_ff <= s2_func_ff;
         s3_setpoint_ff <= s2_setpoint_ff;
         s3_error_ff <= s2_error_in;

         s4_func_ff <= s3_func_ff;
         s4_error_ff <= s3_error_ff;
         s4_derr_ff <= s3_derr_in;
         s4_dset_ff <= s3_dset_in;

         s5_func_ff <= s4_func_ff;
         s5_p_ff <= s4_p_in;
         s5_ie_ff <= s4_ie_in;
         s5_d_ff <= s4_d_in;
         s5_f_ff <= s4_f_in;

         s6_func_ff <= s5_func_ff;
         s6_p_ff <= s5_p_ff;
         s6_i_ff <= integral_in;
         s6_d_ff <= s5_d_ff;
         s6_f_ff <= s5_f_ff;

         rsp_drive_ff <= drive_in;
      end
   end

endmodule

// ===== dv/tb_pid_with_feedforward_core.sv =====
// Self-checking testbench for the PID core with setpoint feedforward.
`timescale 1ns / 1ps

package pid_check_pkg;
   import pwf_pkg::*;

   localparam int HALF_TURN = 205887;
   localparam int FULL_TURN = 2 * HALF_TURN;

   class drive_predictor;
      logic signed [31:0] kp, ki, kd, kf;
      logic [30:0] integ_lim, max_out;
      logic angle_mode;
      logic signed [31:0] prev_error, integ, prev_setpoint, last_drive;
      logic signed [31:0] expected_drive[$];
      int errors;

      function new();
         kp = '0;
         ki = '0;
         kd = '0;
         kf = '0;
         integ_lim = '0;
         max_out = '0;
         angle_mode = 1'b0;
         prev_error = '0;
         integ = '0;
         prev_setpoint = '0;
         last_drive = '0;
         errors = 0;
      endfunction

      function logic signed [31:0] sat_word(longint v);
         if (v > 64'sd2147483647) return 32'sh7fff_ffff;
         if (v < -64'sd2147483648) return 32'sh8000_0000;
         return v[31:0];
      endfunction

      function logic signed [31:0] clamp_to(longint v, logic [30:0] lim);
         longint l;
         l = lim;
         if (v > l) return l[31:0];
         if (v < -l) return -l[31:0];
         return v[31:0];
      endfunction

      function logic signed [31:0] q16_product(logic signed [31:0] a, logic signed [31:0] b);
         longint p;
         p = longint'(a) * longint'(b);
         p = (p + 64'sd32768) >>> 16;
         return sat_word(p);
      endfunction

      function logic signed [31:0] loop_error(logic signed [31:0] sp, logic signed [31:0] fb);
         longint e;
         longint n;
         e = longint'(sp) - longint'(fb);
         if (!angle_mode) return sat_word(e);
         if (e > longint'(HALF_TURN)) begin
            n = (e - HALF_TURN + FULL_TURN - 1) / FULL_TURN;
            e = e - n * FULL_TURN;
         end else if (e < -longint'(HALF_TURN)) begin
            n = (-longint'(HALF_TURN) - e + FULL_TURN - 1) / FULL_TURN;
            e = e + n * FULL_TURN;
         end
         return e[31:0];
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] v);
         case (idx)
            CSR_KP: kp = v;
            CSR_KI: ki = v;
            CSR_KD: kd = v;
            CSR_KF: kf = v;
            CSR_INTEG_LIM: integ_lim = v[30:0];
            CSR_MAX_OUT: max_out = v[30:0];
            CSR_ANGLE_MODE: angle_mode = v[0];
            default: ;
         endcase
      endfunction

      function void note_request(logic [1:0] f, logic signed [31:0] sp,
                                 logic signed [31:0] fb);
         logic signed [31:0] e, de, ds, p_term, d_term, f_term;
         longint total;
         case (f)
            FUNC_CALC: begin
               e = loop_error(sp, fb);
               de = sat_word(longint'(e) - longint'(prev_error));
               ds = sat_word(longint'(sp) - longint'(prev_setpoint));
               p_term = q16_product(kp, e);
               integ = clamp_to(longint'(sat_word(longint'(integ) +
                                                  longint'(q16_product(ki, e)))), integ_lim);
               d_term = q16_product(kd, de);
               f_term = q16_product(kf, ds);
               total = longint'(p_term) + longint'(integ) + longint'(d_term) +
                       longint'(f_term);
               last_drive = clamp_to(total, max_out);
               prev_error = e;
               prev_setpoint = sp;
            end
            FUNC_ALIGN: begin
               prev_error = loop_error(sp, fb);
               prev_setpoint = sp;
               integ = '0;
               last_drive = '0;
            end
            FUNC_CLEAR: begin
               prev_setpoint = sp;
               integ = '0;
               last_drive = '0;
            end
            default: begin
               prev_error = '0;
               integ = '0;
               prev_setpoint = '0;
               last_drive = '0;
            end
         endcase
         expected_drive.push_back(last_drive);
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) $display("%s", msg);
      endfunction

      function void compare_drive(logic signed [31:0] got);
         logic signed [31:0] want;
         if (expected_drive.size() == 0) begin
            flag($sformatf("drive item %0d arrived with none expected", got));
         end else begin
            want = expected_drive.pop_front();
            if (got !== want) begin
               flag($sformatf("drive mismatch: expected %0d, got %0d", want, got));
            end
         end
      endfunction

      function int outstanding();
         return expected_drive.size();
      endfunction

      function void close_out();
         if (expected_drive.size() != 0) begin
            flag($sformatf("%0d drive items never arrived", expected_drive.size()));
         end
      endfunction
   endclass

endpackage

module tb_pid_with_feedforward_core;
   import pwf_pkg::*;
   import pid_check_pkg::*;

   localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [1:0] req_func;
   logic signed [31:0] req_setpoint;
   logic signed [31:0] req_feedback;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_drive;
   logic csr_wr_en;
   logic [2:0] csr_index;
   logic [31:0] csr_wdata;

   int send_idle_pct;
   int recv_idle_pct;
   int hold_reqs;
   int hold_seen = 0;
   int hold_left = 0;

   drive_predictor sb;

   pid_with_feedforward_core u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_setpoint(req_setpoint),
      .req_feedback(req_feedback),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_drive(rsp_drive),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_func, req_setpoint, req_feedback);
         if (rsp_valid && !rsp_stall) sb.compare_drive(rsp_drive);
      end
   end

   // A new hold request from the stimulus holds the result side for a long stretch.
   always @(posedge clock) begin
      if (hold_seen != hold_reqs) begin
         hold_seen <= hold_reqs;
         hold_left <= 300;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   task automatic send_item(input logic [1:0] f, input logic signed [31:0] s,
                            input logic signed [31:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_setpoint <= s;
      req_feedback <= b;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   task automatic load_settings(input logic [31:0] g_p, input logic [31:0] g_i,
                                input logic [31:0] g_d, input logic [31:0] g_f,
                                input logic [31:0] lim_i, input logic [31:0] lim_o,
                                input logic ang);
      logic [2:0] idx[7];
      logic [31:0] val[7];
      idx = '{CSR_KP, CSR_KI, CSR_KD, CSR_KF, CSR_INTEG_LIM, CSR_MAX_OUT, CSR_ANGLE_MODE};
      val = '{g_p, g_i, g_d, g_f, lim_i, lim_o, {31'd0, ang}};
      for (int i = 0; i < 7; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         sb.set_reg(idx[i], val[i]);
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [31:0] rand_gain();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return int'($urandom_range(0, 2 ** 18)) - 2 ** 17;
   endfunction

   function automatic logic [31:0] rand_limit();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return $urandom_range(0, 2 ** 24);
   endfunction

   function automatic logic signed [31:0] rand_q16();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 3))
               0: return Q_MAX;
               1: return Q_MIN;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         default: return int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
      endcase
   endfunction

   task automatic send_random();
      logic [1:0] f;
      logic signed [31:0] s, b;
      int r, off;
      r = $urandom_range(0, 19);
      if (r < 14) f = FUNC_CALC;
      else if (r < 16) f = FUNC_ALIGN;
      else if (r < 18) f = FUNC_CLEAR;
      else f = FUNC_ZERO;
      s = rand_q16();
      b = rand_q16();
      // Error exactly on the wrap boundary, possibly several turns out.
      if (f == FUNC_CALC && $urandom_range(0, 7) == 0) begin
         off = HALF_TURN + FULL_TURN * int'($urandom_range(0, 2));
         if ($urandom_range(0, 1) == 1) off = -off;
         s = int'($urandom_range(0, 2 ** 20)) - 2 ** 19;
         b = s - off;
      end
      send_item(f, s, b);
   endtask

   initial begin
      sb = new();
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_CALC;
      req_setpoint = '0;
      req_feedback = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_KP;
      csr_wdata = '0;
      hold_reqs = 0;
      send_idle_pct = 11;
      recv_idle_pct = 46;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      load_settings(Q_ONE, 32'h8000, 32'h4000, 32'h2000, 32'd10 << 16, 32'd100 << 16, 1'b0);
      send_item(FUNC_CALC, 0, 0);
      send_item(FUNC_CALC, Q_ONE, 0);
      send_item(FUNC_CALC, 2 * Q_ONE, Q_ONE);
      send_item(FUNC_CALC, Q_MAX, Q_MIN);
      send_item(FUNC_CALC, Q_MIN, Q_MAX);
      send_item(FUNC_CALC, Q_MAX, -1);
      send_item(FUNC_ALIGN, 5 * Q_ONE, Q_ONE);
      send_item(FUNC_CALC, 5 * Q_ONE, 2 * Q_ONE);
      send_item(FUNC_CLEAR, 3 * Q_ONE, 0);
      send_item(FUNC_CALC, 3 * Q_ONE, 0);
      send_item(FUNC_ZERO, Q_MAX, Q_MIN);
      send_item(FUNC_CALC, -1, 1);
      drain();

      load_settings(Q_MAX, Q_MIN, Q_MIN, Q_MAX, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
      send_item(FUNC_CALC, HALF_TURN, 0);
      send_item(FUNC_CALC, -HALF_TURN, 0);
      send_item(FUNC_CALC, HALF_TURN + 1, 0);
      send_item(FUNC_CALC, -HALF_TURN - 1, 0);
      send_item(FUNC_CALC, Q_MAX, Q_MIN);
      send_item(FUNC_CALC, Q_MIN, Q_MAX);
      send_item(FUNC_ALIGN, 3 * FULL_TURN, 0);
      send_item(FUNC_CALC, 0, 0);
      send_item(FUNC_CALC, Q_MAX, 0);
      send_item(FUNC_ZERO, 0, 0);
      send_item(FUNC_CALC, 1, 0);
      drain();

      load_settings(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 32'd0, 32'd0, 1'b0);
      send_item(FUNC_CALC, Q_MAX, Q_MIN);
      send_item(FUNC_CALC, 32'sh8000, 0);
      drain();

      for (int seg = 0; seg < 8; seg++) begin
         if (seg < 3) begin
            send_idle_pct = 11;
            recv_idle_pct <= 46;
         end else if (seg < 6) begin
            send_idle_pct = 46;
            recv_idle_pct <= 11;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
         end
         drain();
         case (seg)
            0: load_settings(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
            1: load_settings(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 32'd0, 32'h7fff_ffff, 1'b0);
            2: load_settings(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                             rand_limit(), 32'd0, 1'($urandom_range(0, 1)));
            default: load_settings(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                                   rand_limit(), rand_limit(), 1'($urandom_range(0, 1)));
         endcase
         for (int i = 0; i < 100; i++) begin
            if ((seg == 4 || seg == 6) && i == 20) hold_reqs <= hold_reqs + 1;
            if (seg == 5 && i == 50) drain();
            send_random();
         end
      end

      drain();
      repeat (20) @(posedge clock);
      sb.close_out();
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
